/* src/assert_macros.svh */
// Assertion macros used by the checker file of the BMP stream formatter.
// Needs nothing else; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent true in a cycle requires the consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Antecedent true in a cycle requires the consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* src/bmpsf_pkg.sv */
// Package of the BMP stream formatter: constants, register indexes, the
// per-pixel command and header structs, and the header byte function. No dependencies.
package bmpsf_pkg;

    localparam int unsigned MAX_DIMENSION = 8192;
    localparam int DIM_W = 14;
    localparam int COUNT_W = 13;
    localparam int ROW_BYTES_W = 15;
    localparam int IDX_W = 6;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] REG_IMAGE_WIDTH = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_X_RESOLUTION = 2'd2;
    localparam logic [1:0] REG_Y_RESOLUTION = 2'd3;

    localparam logic [7:0] PAD_BYTE = 8'hFF;
    localparam logic [IDX_W-1:0] HEADER_BYTES = 6'd54;
    localparam logic [31:0] HEADER_LEN = 32'd54;
    localparam logic [31:0] INFO_SIZE = 32'd40;
    // Planes (1) and bit depth (24) packed as one little-endian word.
    localparam logic [31:0] PLANES_DEPTH = 32'h0018_0001;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       header;
        logic [1:0] pad;
        logic       image_done;
    } cmd_t;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [31:0]      file_len;
        logic [31:0]      x_res;
        logic [31:0]      y_res;
    } hdr_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIMENSION)) begin
            r = DIM_W'(MAX_DIMENSION);
        end
        return r;
    endfunction

    // Byte idx (0..53) of the file header. Every field after the signature but bit
    // depth starts on a four-byte boundary counted from byte two.
    function automatic logic [7:0] header_byte(input logic [IDX_W-1:0] idx,
                                               input hdr_t hdr);
        logic [IDX_W-1:0] rel;
        logic [31:0] word;
        logic [7:0] r;
        rel = idx - IDX_W'(2);
        unique case (rel[5:2])
            4'd0: word = hdr.file_len;
            4'd2: word = HEADER_LEN;
            4'd3: word = INFO_SIZE;
            4'd4: word = 32'(hdr.width);
            4'd5: word = 32'(hdr.height);
            4'd6: word = PLANES_DEPTH;
            4'd9: word = hdr.x_res;
            4'd10: word = hdr.y_res;
            default: word = '0;
        endcase
        r = word[{rel[1:0], 3'b000} +: 8];
        if (idx == IDX_W'(0)) begin
            r = 8'h42;
        end else if (idx == IDX_W'(1)) begin
            r = 8'h4D;
        end
        return r;
    endfunction

endpackage

/* src/bmpsf_front.sv */
// Front of the BMP stream formatter: configuration registers, row and column
// counters, and classification of each pixel into a command. Uses bmpsf_pkg.
module bmpsf_front import bmpsf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_index,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_red,
    input  logic [7:0]  s_green,
    input  logic [7:0]  s_blue,
    input  logic        q_full,
    output logic        q_push,
    output cmd_t        q_cmd,
    output hdr_t        hdr
);

    logic [DIM_W-1:0] width_reg, height_reg;
    logic [31:0] x_res_reg, y_res_reg;
    logic [DIM_W-1:0] width_hdr_reg, height_hdr_reg;
    logic [ROW_BYTES_W-1:0] row_bytes_reg;
    logic [31:0] file_len_reg;
    logic header_pending_reg, header_pending_next;
    logic [COUNT_W-1:0] column_count_reg, column_count_next;
    logic [COUNT_W-1:0] row_count_reg, row_count_next;

    logic [DIM_W-1:0] w_eff, h_eff;
    logic [DIM_W-1:0] col_inc, row_inc;
    logic row_end, image_end;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= DIM_W'(1);
            height_reg <= DIM_W'(1);
            x_res_reg <= '0;
            y_res_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_IMAGE_WIDTH: width_reg <= cfg_wr_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_wr_data[DIM_W-1:0];
                REG_X_RESOLUTION: x_res_reg <= cfg_wr_data;
                REG_Y_RESOLUTION: y_res_reg <= cfg_wr_data;
            endcase
        end
    end

    assign w_eff = clamp_dim(width_reg);
    assign h_eff = clamp_dim(height_reg);

    // Header values settle through these registers after a write (width, height and row bytes,
    // then file length), well before the back end reaches the first header field that uses them.
    always_ff @(posedge aclk) begin
        width_hdr_reg <= w_eff;
        height_hdr_reg <= h_eff;
        row_bytes_reg <= ROW_BYTES_W'({w_eff, 1'b0}) + ROW_BYTES_W'(w_eff)
                         + ROW_BYTES_W'(w_eff[1:0]);
        file_len_reg <= HEADER_LEN + 32'(row_bytes_reg) * 32'(height_hdr_reg);
    end

    assign hdr = '{width: width_hdr_reg, height: height_hdr_reg,
                   file_len: file_len_reg, x_res: x_res_reg, y_res: y_res_reg};

    assign s_ready = !q_full;
    assign q_push = s_valid && s_ready;

    assign col_inc = DIM_W'(column_count_reg) + DIM_W'(1);
    assign row_inc = DIM_W'(row_count_reg) + DIM_W'(1);
    assign row_end = col_inc >= w_eff;
    assign image_end = row_end && (row_inc >= h_eff);

    // Pad bytes per row: (4 - 3w mod 4) mod 4 equals w mod 4.
    assign q_cmd = '{blue: s_blue, green: s_green, red: s_red,
                     header: header_pending_reg,
                     pad: row_end ? w_eff[1:0] : 2'd0,
                     image_done: image_end};

    always_comb begin
        header_pending_next = header_pending_reg;
        column_count_next = column_count_reg;
        row_count_next = row_count_reg;
        if (q_push) begin
            header_pending_next = image_end;
            if (!row_end) begin
                column_count_next = col_inc[COUNT_W-1:0];
            end else begin
                column_count_next = '0;
                row_count_next = image_end ? '0 : row_inc[COUNT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_pending_reg <= 1'b1;
            column_count_reg <= '0;
            row_count_reg <= '0;
        end else begin
            header_pending_reg <= header_pending_next;
            column_count_reg <= column_count_next;
            row_count_reg <= row_count_next;
        end
    end

endmodule

/* src/bmpsf_queue.sv */
// Two-entry command queue between the front and back of the BMP stream
// formatter. Uses bmpsf_pkg for the command type.
module bmpsf_queue import bmpsf_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output cmd_t head_cmd
);

    cmd_t entry_reg [QUEUE_DEPTH];
    logic wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign full = count_reg == 2'(QUEUE_DEPTH);
    assign not_empty = count_reg != 2'd0;
    assign head_cmd = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

/* src/bmpsf_back.sv */
// Back of the BMP stream formatter: walks the bytes of one command (header,
// pixel, padding) into a registered output stage. Uses bmpsf_pkg.
module bmpsf_back import bmpsf_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_not_empty,
    input  cmd_t       q_cmd,
    output logic       q_pop,
    input  hdr_t       hdr,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_run_last,
    output logic       m_image_last
);

    cmd_t cmd_reg;
    logic active_reg;
    logic [IDX_W-1:0] idx_reg;
    logic valid_reg;
    logic [7:0] byte_reg;
    logic run_last_reg, image_last_reg;

    logic advance, at_last;
    logic [IDX_W-1:0] last_idx;
    logic [7:0] cur_byte;

    // Byte 54 onward: blue, green, red, then the row padding.
    assign last_idx = HEADER_BYTES + IDX_W'(2) + IDX_W'(cmd_reg.pad);
    assign at_last = idx_reg == last_idx;
    assign advance = !valid_reg || m_ready;
    assign q_pop = advance && q_not_empty && (!active_reg || at_last);

    always_comb begin
        if (idx_reg < HEADER_BYTES) begin
            cur_byte = header_byte(idx_reg, hdr);
        end else if (idx_reg == HEADER_BYTES) begin
            cur_byte = cmd_reg.blue;
        end else if (idx_reg == HEADER_BYTES + IDX_W'(1)) begin
            cur_byte = cmd_reg.green;
        end else if (idx_reg == HEADER_BYTES + IDX_W'(2)) begin
            cur_byte = cmd_reg.red;
        end else begin
            cur_byte = PAD_BYTE;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cmd_reg <= q_cmd;
        end
        if (advance && active_reg) begin
            byte_reg <= cur_byte;
            run_last_reg <= at_last;
            image_last_reg <= at_last && cmd_reg.image_done;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            idx_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                valid_reg <= active_reg;
            end
            if (q_pop) begin
                active_reg <= 1'b1;
                idx_reg <= q_cmd.header ? '0 : HEADER_BYTES;
            end else if (advance && active_reg) begin
                idx_reg <= idx_reg + IDX_W'(1);
                if (at_last) begin
                    active_reg <= 1'b0;
                end
            end
        end
    end

    assign m_valid = valid_reg;
    assign m_out_byte = byte_reg;
    assign m_run_last = run_last_reg;
    assign m_image_last = image_last_reg;

endmodule

/* src/bmp_stream_formatter.sv */
// Top level of the BMP stream formatter: front classifier, command queue and
// byte sequencer. Uses bmpsf_pkg, bmpsf_front, bmpsf_queue and bmpsf_back.
//
//   Channel   Direction  Handshake           Beat
//   s_        in         s_valid / s_ready   one RGB pixel
//   m_        out        m_valid / m_ready   one file byte with run and image flags
//   cfg_      in         cfg_wr_en           one register write, no wait
//
// Each pixel becomes three output bytes, plus 54 header bytes before the first
// pixel of an image and up to three pad bytes at a row end; the byte-wide output
// stage sets the pace. A pixel is accepted whenever the two-entry queue has room,
// so input and output stall independently. Reset is synchronous and clears the
// counters, the queue and the output stage; registers return to width 1, height 1.
module bmp_stream_formatter import bmpsf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_index,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_red,
    input  logic [7:0]  s_green,
    input  logic [7:0]  s_blue,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_run_last,
    output logic        m_image_last
);

    logic q_push, q_full, q_pop, q_not_empty;
    cmd_t push_cmd, head_cmd;
    hdr_t hdr;

    bmpsf_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_red        (s_red),
        .s_green      (s_green),
        .s_blue       (s_blue),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (push_cmd),
        .hdr          (hdr)
    );

    bmpsf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    bmpsf_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_not_empty  (q_not_empty),
        .q_cmd        (head_cmd),
        .q_pop        (q_pop),
        .hdr          (hdr),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_run_last   (m_run_last),
        .m_image_last (m_image_last)
    );

endmodule

/* src/bmpsf_checker.sv */
// Port-level checker of the BMP stream formatter, bound to the top level.
// Uses assert_macros.svh.
`include "assert_macros.svh"

module bmpsf_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic       m_run_last,
    input logic       m_image_last
);

    logic in_beat, out_beat, run_beat;
    logic [2:0] pending_reg;
    logic expect_sig_reg;

    assign in_beat = s_valid && s_ready;
    assign out_beat = m_valid && m_ready;
    assign run_beat = out_beat && m_run_last;

    // Pixels accepted whose last byte has not yet been taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
            expect_sig_reg <= 1'b1;
        end else begin
            if (in_beat && !run_beat) begin
                pending_reg <= pending_reg + 3'd1;
            end else if (run_beat && !in_beat) begin
                pending_reg <= pending_reg - 3'd1;
            end
            if (out_beat) begin
                expect_sig_reg <= m_image_last;
            end
        end
    end

    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_out_byte))
    `ASSERT_IMPLIES(a_image_last_ends_run, aclk, aresetn, m_valid && m_image_last, m_run_last)
    `ASSERT_IMPLIES(a_no_invented_bytes, aclk, aresetn, m_valid, pending_reg != 3'd0)
    `ASSERT_IMPLIES(a_file_starts_bm, aclk, aresetn, m_valid && expect_sig_reg, m_out_byte == 8'h42)

endmodule

bind bmp_stream_formatter bmpsf_checker u_bmpsf_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_out_byte   (m_out_byte),
    .m_run_last   (m_run_last),
    .m_image_last (m_image_last)
);

/* tb/bmp_stream_formatter_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench of bmp_stream_formatter: random pixel beats under changing
// image settings, with the expected BMP byte stream computed alongside and compared beat by beat.
// Depends on bmpsf_pkg and the bmp_stream_formatter RTL.
module bmp_stream_formatter_tb import bmpsf_pkg::*; ();

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD = 400;
    localparam int RAND_PHASES = 12;
    localparam int END_SETTLE = 20;

    localparam logic [7:0] SIG_B = 8'h42;
    localparam logic [7:0] SIG_M = 8'h4D;
    localparam logic [31:0] BMP_PLANES = 32'd1;
    localparam logic [31:0] BMP_DEPTH = 32'd24;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       image_last;
    } file_byte_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [1:0]  cfg_wr_index;
    logic [31:0] cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_red;
    logic [7:0]  s_green;
    logic [7:0]  s_blue;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_out_byte;
    logic        m_run_last;
    logic        m_image_last;

    pixel_t     pixel_q[$];
    file_byte_t expected_bytes[$];

    // Shadow copy of the formatter's registers and counters.
    logic [DIM_W-1:0] fmt_width;
    logic [DIM_W-1:0] fmt_height;
    logic [31:0]      fmt_xres;
    logic [31:0]      fmt_yres;
    bit               fmt_hdr_pending;
    int unsigned      fmt_col;
    int unsigned      fmt_row;

    bit     pixel_taken;
    bit     src_steady;
    bit     snk_steady;
    bit     hold_request;
    int     src_gap;
    int     snk_stall;
    int     idle_cycles;
    int     err_count;
    pixel_t drv_pixel;

    bmp_stream_formatter DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_red        (s_red),
        .s_green      (s_green),
        .s_blue       (s_blue),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_run_last   (m_run_last),
        .m_image_last (m_image_last)
    );

    always #5 aclk = ~aclk;

    function automatic int unsigned used_dim(input logic [DIM_W-1:0] v);
        if (v == '0) return 1;
        if (v > MAX_DIMENSION) return MAX_DIMENSION;
        return 32'(v);
    endfunction

    function automatic int unsigned row_pad(input int unsigned w);
        return (4 - ((w * 3) & 3)) & 3;
    endfunction

    function automatic int pick_gap(input bit steady);
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim(input int unsigned small_max);
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return DIM_W'($urandom_range(1, small_max));
        if (r < 85) return DIM_W'($urandom_range(9, 40));
        if (r < 90) return '0;
        if (r < 94) return DIM_W'(MAX_DIMENSION);
        if (r < 97) return DIM_W'($urandom_range(MAX_DIMENSION + 1, 16383));
        return DIM_W'($urandom_range(1, 16383));
    endfunction

    function automatic logic [31:0] pick_res();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) return '0;
        if (r < 4) return '1;
        return $urandom();
    endfunction

    function automatic pixel_t rand_pixel();
        pixel_t p;
        int r;
        p = pixel_t'(24'($urandom()));
        r = $urandom_range(0, 19);
        if (r == 0) p = '0;
        else if (r == 1) p = '1;
        return p;
    endfunction

    task automatic queue_pixel(input pixel_t p);
        pixel_q = {pixel_q, p};
    endtask

    task automatic push_file_byte(input logic [7:0] b);
        file_byte_t fb;
        fb = '{data: b, run_last: 1'b0, image_last: 1'b0};
        expected_bytes = {expected_bytes, fb};
    endtask

    task automatic push_le_field(input logic [31:0] v, input int nbytes);
        for (int i = 0; i < nbytes; i++) push_file_byte(v[8*i +: 8]);
    endtask

    // Expected file bytes for one accepted pixel, header first when an image begins.
    task automatic predict_pixel(input pixel_t px);
        int unsigned w;
        int unsigned h;
        int unsigned file_len;
        bit          img_done;
        file_byte_t  tail;
        w = used_dim(fmt_width);
        h = used_dim(fmt_height);
        img_done = 1'b0;
        if (fmt_hdr_pending) begin
            file_len = HEADER_LEN + (w * 3 + row_pad(w)) * h;
            push_file_byte(SIG_B);
            push_file_byte(SIG_M);
            push_le_field(file_len, 4);
            push_le_field('0, 4);
            push_le_field(HEADER_LEN, 4);
            push_le_field(INFO_SIZE, 4);
            push_le_field(w, 4);
            push_le_field(h, 4);
            push_le_field(BMP_PLANES, 2);
            push_le_field(BMP_DEPTH, 2);
            push_le_field('0, 4);
            push_le_field('0, 4);
            push_le_field(fmt_xres, 4);
            push_le_field(fmt_yres, 4);
            push_le_field('0, 4);
            push_le_field('0, 4);
            fmt_hdr_pending = 1'b0;
        end
        push_file_byte(px.blue);
        push_file_byte(px.green);
        push_file_byte(px.red);
        fmt_col++;
        // A shrunken width mid-row still ends the row on the next pixel.
        if (fmt_col >= w) begin
            repeat (row_pad(w)) push_file_byte(PAD_BYTE);
            fmt_col = 0;
            fmt_row++;
            if (fmt_row >= h) begin
                fmt_row = 0;
                fmt_hdr_pending = 1'b1;
                img_done = 1'b1;
            end
        end
        tail = expected_bytes.pop_back();
        tail.run_last = 1'b1;
        tail.image_last = img_done;
        expected_bytes = {expected_bytes, tail};
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= val;
        case (idx)
            REG_IMAGE_WIDTH: fmt_width = val[DIM_W-1:0];
            REG_IMAGE_HEIGHT: fmt_height = val[DIM_W-1:0];
            REG_X_RESOLUTION: fmt_xres = val;
            REG_Y_RESOLUTION: fmt_yres = val;
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_image(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                             input logic [31:0] xres, input logic [31:0] yres);
        logic [31:0] junk;
        junk = $urandom();
        write_reg(REG_IMAGE_WIDTH, {junk[31:DIM_W], w});
        write_reg(REG_IMAGE_HEIGHT, {junk[DIM_W +: 32-DIM_W], h});
        write_reg(REG_X_RESOLUTION, xres);
        write_reg(REG_Y_RESOLUTION, yres);
        end_writes();
    endtask

    task automatic random_config();
        logic [31:0] junk;
        junk = $urandom();
        if ($urandom_range(0, 3) != 0)
            write_reg(REG_IMAGE_WIDTH, {junk[31:DIM_W], pick_dim(8)});
        if ($urandom_range(0, 3) != 0)
            write_reg(REG_IMAGE_HEIGHT, {junk[DIM_W +: 32-DIM_W], pick_dim(4)});
        if ($urandom_range(0, 2) == 0)
            write_reg(REG_X_RESOLUTION, pick_res());
        if ($urandom_range(0, 2) == 0)
            write_reg(REG_Y_RESOLUTION, pick_res());
        end_writes();
    endtask

    // Waits until every queued pixel is taken and every expected byte has come out.
    task automatic drain();
        while (pixel_q.size() != 0 || s_valid || expected_bytes.size() != 0)
            @(posedge aclk);
    endtask

    // Pixel driver.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || pixel_taken) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (pixel_q.size() != 0) begin
                    drv_pixel = pixel_q.pop_front();
                    s_red <= drv_pixel.red;
                    s_green <= drv_pixel.green;
                    s_blue <= drv_pixel.blue;
                    s_valid <= 1'b1;
                    src_gap = pick_gap(src_steady);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Byte sink with random stalls and, on request, one long hold-off.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (hold_request) begin
                snk_stall = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (snk_stall > 0) begin
                snk_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                snk_stall = pick_gap(snk_steady);
            end
        end
    end

    // Monitor: predicts on every pixel beat and checks every byte beat.
    always @(posedge aclk) begin
        file_byte_t want;
        pixel_taken = s_valid && s_ready;
        if (aresetn) begin
            if (pixel_taken) predict_pixel({s_red, s_green, s_blue});
            if (m_valid && m_ready) begin
                if (expected_bytes.size() == 0) begin
                    $error("unexpected byte beat: out_byte %02h", m_out_byte);
                    err_count++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_out_byte !== want.data) begin
                        $error("out_byte: expected %02h, actual %02h", want.data, m_out_byte);
                        err_count++;
                    end
                    if (m_run_last !== want.run_last) begin
                        $error("run_last: expected %0b, actual %0b", want.run_last, m_run_last);
                        err_count++;
                    end
                    if (m_image_last !== want.image_last) begin
                        $error("image_last: expected %0b, actual %0b",
                               want.image_last, m_image_last);
                        err_count++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int n;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_index = '0;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_red = '0;
        s_green = '0;
        s_blue = '0;
        m_ready = 1'b0;
        fmt_width = DIM_W'(1);
        fmt_height = DIM_W'(1);
        fmt_xres = '0;
        fmt_yres = '0;
        fmt_hdr_pending = 1'b1;
        fmt_col = 0;
        fmt_row = 0;
        src_steady = 1'b0;
        snk_steady = 1'b0;
        hold_request = 1'b0;
        src_gap = 0;
        snk_stall = 0;
        idle_cycles = 0;
        err_count = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Register values after reset: one-pixel images, each a whole file.
        queue_pixel({8'h00, 8'h00, 8'h00});
        queue_pixel({8'hFF, 8'hFF, 8'hFF});
        drain();

        // Zero dimensions are used as one.
        set_image('0, '0, 32'hFFFF_FFFF, 32'hA5A5_5A5A);
        queue_pixel({8'h80, 8'h01, 8'h7F});
        drain();

        // Two rows of three pixels, three pad bytes per row.
        set_image(DIM_W'(3), DIM_W'(2), '0, 32'hFFFF_FFFF);
        repeat (6) queue_pixel(rand_pixel());
        drain();

        // Oversized dimensions are clamped, and the image is left open.
        set_image(DIM_W'(16383), DIM_W'(16383), 32'd1, 32'd1);
        repeat (3) queue_pixel(rand_pixel());
        drain();

        // Width below the column count ends the row and the image at once.
        set_image(DIM_W'(2), DIM_W'(1), 32'h0000_0B13, 32'h0000_0B13);
        queue_pixel({8'hFF, 8'h00, 8'hFF});
        drain();

        // Settings changed mid-image keep the counters running.
        set_image(DIM_W'(5), DIM_W'(3), 32'h1234_5678, 32'h8765_4321);
        repeat (3) queue_pixel(rand_pixel());
        drain();
        write_reg(REG_IMAGE_WIDTH, 32'd4);
        end_writes();
        queue_pixel(rand_pixel());
        drain();
        write_reg(REG_IMAGE_HEIGHT, 32'd2);
        end_writes();
        repeat (4) queue_pixel(rand_pixel());
        drain();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            random_config();
            src_steady = ($urandom_range(0, 3) == 0);
            snk_steady = ($urandom_range(0, 3) == 0);
            // The sink holds off while the source keeps offering, so the input backs up.
            if (ph == 0 || ph == RAND_PHASES / 2) begin
                src_steady = 1'b1;
                hold_request = 1'b1;
            end
            n = $urandom_range(20, 45);
            repeat (n) queue_pixel(rand_pixel());
            drain();
        end

        repeat (END_SETTLE) @(posedge aclk);
        if (err_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+src
src/bmpsf_pkg.sv
src/bmpsf_front.sv
src/bmpsf_queue.sv
src/bmpsf_back.sv
src/bmp_stream_formatter.sv
src/bmpsf_checker.sv
tb/bmp_stream_formatter_tb.sv
